FILE: rtl/ddf_pkg.sv
// shared types and constants for the decimal digit formatter
package ddf_pkg;

  // number of shift-add-3 pipeline stages
  localparam int unsigned NUM_STAGES = 4;
  // bcd digits held in flight, enough for a 32-bit value
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned COUNT_W    = 4;

  // character codes
  localparam logic [5:0] CODE_SPACE = 6'h20;
  localparam logic [5:0] CODE_ZERO  = 6'h30;

  // reset value of the font height register
  localparam logic [7:0] FONT_SIZE_RST = 8'd16;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // item fields that ride along with the conversion
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [7:0]         start_column;
    logic [7:0]         row;
  } ddf_meta_t;

endpackage

FILE: rtl/ddf_dabble_stage.sv
// one pipeline stage of the binary to bcd conversion (several shift-add-3 steps)
module ddf_dabble_stage
  import ddf_pkg::*;
#(
  parameter int unsigned BIN_W = 32,
  parameter int unsigned STEPS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bcd_t             bcd_i,
  input  logic [BIN_W-1:0] bin_i,
  input  ddf_meta_t        meta_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bcd_t             bcd_o,
  output logic [BIN_W-1:0] bin_o,
  output ddf_meta_t        meta_o
);

  logic             valid_q;
  bcd_t             bcd_q, bcd_d;
  logic [BIN_W-1:0] bin_q, bin_d;
  ddf_meta_t        meta_q;

  // stage can take a new item when empty or when its item moves on
  assign ready_o = !valid_q || ready_i;

  // shift-add-3 steps of this stage
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < int'(STEPS); s++) begin
      for (int d = 0; d < int'(BCD_DIGITS); d++) begin
        if (bcd_d[d] >= 4'd5) begin
          bcd_d[d] = bcd_d[d] + 4'd3;
        end
      end
      {bcd_d, bin_d} = {bcd_d, bin_d} << 1;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bcd_q  <= bcd_d;
      bin_q  <= bin_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;
  assign meta_o  = meta_q;

endmodule

FILE: rtl/decimal_digit_formatter.sv
// top level: pipelined binary to bcd conversion followed by a character emitter
// throughput: one character per cycle while the emitter is active; an item with n positions
//   holds the emitter for its n characters and the four conversion stages buffer four more items
// busy_o rises only when the emitter and every conversion stage are occupied
// reset: async active low, clears valid bits and the emitter, font size returns to 16
module decimal_digit_formatter
  import ddf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = 10,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [COUNT_W-1:0]     digit_count_i,
  input  logic [7:0]             start_column_i,
  input  logic [7:0]             row_i,
  // configuration
  input  logic                   font_size_we_i,
  input  logic [7:0]             font_size_i,
  // results
  output logic                   char_valid_o,
  output logic [7:0]             column_o,
  output logic [7:0]             row_out_o,
  output logic [5:0]             char_code_o,
  output logic                   is_last_o
);

  localparam int unsigned STEPS = (VALUE_WIDTH + NUM_STAGES - 1) / NUM_STAGES;
  localparam int unsigned PAD_W = NUM_STAGES * STEPS;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

  // font height register
  logic [7:0] font_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_size_q <= FONT_SIZE_RST;
    end else if (font_size_we_i) begin
      font_size_q <= font_size_i;
    end
  end

  // conversion pipeline
  logic             pv    [NUM_STAGES+1];
  logic             pr    [NUM_STAGES+1];
  bcd_t             pbcd  [NUM_STAGES+1];
  logic [PAD_W-1:0] pbin  [NUM_STAGES+1];
  ddf_meta_t        pmeta [NUM_STAGES+1];

  assign pv[0]    = start_i;
  assign busy_o   = !pr[0];
  assign pbcd[0]  = '0;
  assign pbin[0]  = PAD_W'(value_i);
  assign pmeta[0] = '{count: digit_count_i, start_column: start_column_i, row: row_i};

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    ddf_dabble_stage #(
      .BIN_W (PAD_W),
      .STEPS (STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pv[g]),
      .ready_o (pr[g]),
      .bcd_i   (pbcd[g]),
      .bin_i   (pbin[g]),
      .meta_i  (pmeta[g]),
      .valid_o (pv[g+1]),
      .ready_i (pr[g+1]),
      .bcd_o   (pbcd[g+1]),
      .bin_o   (pbin[g+1]),
      .meta_o  (pmeta[g+1])
    );
  end

  // emitter state
  logic               em_active_q;
  logic [COUNT_W-1:0] pos_q;
  logic               shown_q;
  bcd_t               em_bcd_q;
  logic [7:0]         col_q;
  logic [7:0]         em_row_q;

  logic               em_last;
  logic               em_take;
  logic [COUNT_W-1:0] cnt_sat;
  logic [3:0]         digit;
  logic [5:0]         code;
  logic [7:0]         col_step;

  assign em_last  = (pos_q == '0);
  assign pr[NUM_STAGES] = !em_active_q || em_last;
  assign em_take  = pv[NUM_STAGES] && pr[NUM_STAGES];
  assign cnt_sat  = (pmeta[NUM_STAGES].count > MAX_CNT) ? MAX_CNT
                                                        : pmeta[NUM_STAGES].count;
  assign digit    = em_bcd_q[pos_q];
  assign col_step = {1'b0, font_size_q[7:1]};

  // leading zero blanking
  always_comb begin
    if (!shown_q && !em_last && digit == 4'd0) begin
      code = CODE_SPACE;
    end else begin
      code = CODE_ZERO + {2'b00, digit};
    end
  end

  // emitter control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_active_q <= 1'b0;
      pos_q       <= '0;
      shown_q     <= 1'b0;
    end else if (em_take) begin
      em_active_q <= (cnt_sat != '0);
      pos_q       <= cnt_sat - COUNT_W'(1);
      shown_q     <= 1'b0;
    end else if (em_active_q) begin
      em_active_q <= !em_last;
      pos_q       <= pos_q - COUNT_W'(1);
      shown_q     <= shown_q || (code != CODE_SPACE);
    end
  end

  // emitter payload
  always_ff @(posedge clk_i) begin
    if (em_take) begin
      em_bcd_q <= pbcd[NUM_STAGES];
      col_q    <= pmeta[NUM_STAGES].start_column;
      em_row_q <= pmeta[NUM_STAGES].row;
    end else if (em_active_q) begin
      col_q    <= col_q + col_step;
    end
  end

  // result registers
  logic       out_valid_q;
  logic [7:0] out_col_q;
  logic [7:0] out_row_q;
  logic [5:0] out_code_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= em_active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_active_q) begin
      out_col_q  <= col_q;
      out_row_q  <= em_row_q;
      out_code_q <= code;
      out_last_q <= em_last;
    end
  end

  assign char_valid_o = out_valid_q;
  assign column_o     = out_col_q;
  assign row_out_o    = out_row_q;
  assign char_code_o  = out_code_q;
  assign is_last_o    = out_last_q;

endmodule

FILE: rtl/ddf_checker.sv
// port-level checks for the decimal digit formatter, bound to the top level
module ddf_checker
  import ddf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       char_valid_o,
  input logic [7:0] row_out_o,
  input logic [5:0] char_code_o,
  input logic       is_last_o
);

  // every character is a space or a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (char_code_o == CODE_SPACE) ||
                     (char_code_o >= CODE_ZERO && char_code_o <= CODE_ZERO + 6'd9))
    else $error("character code out of range");

  // the final position is never blanked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && is_last_o) |-> (char_code_o != CODE_SPACE))
    else $error("last position blanked");

  // characters of one number come back to back on the same row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && !is_last_o) |=> (char_valid_o && $stable(row_out_o)))
    else $error("gap or row change inside a number");

  // once a digit is shown, no blank follows within the number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && !is_last_o && char_code_o != CODE_SPACE)
      |=> (char_code_o != CODE_SPACE))
    else $error("blank after a shown digit");

endmodule

bind decimal_digit_formatter ddf_checker u_ddf_checker (.*);

FILE: tb/tb_decimal_digit_formatter.sv
// testbench for decimal_digit_formatter: directed table plus random numbers, self-checking
`timescale 1ns / 1ps

module tb_decimal_digit_formatter;
  import ddf_pkg::*;

  localparam int unsigned MAX_POS     = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS = 15;

  // one number to format
  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [7:0]         start;
    logic [7:0]         row;
  } number_req_t;

  // one emitted character
  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    logic [5:0] code;
    logic       is_last;
  } digit_char_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               busy_o;
  logic [VAL_W-1:0]   value_i        = '0;
  logic [COUNT_W-1:0] digit_count_i  = '0;
  logic [7:0]         start_column_i = '0;
  logic [7:0]         row_i          = '0;
  logic               font_size_we_i = 1'b0;
  logic [7:0]         font_size_i    = FONT_SIZE_RST;
  logic               char_valid_o;
  logic [7:0]         column_o;
  logic [7:0]         row_out_o;
  logic [5:0]         char_code_o;
  logic               is_last_o;

  decimal_digit_formatter #(
    .MAX_DIGITS (MAX_POS),
    .VALUE_WIDTH(VAL_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .start_column_i(start_column_i),
    .row_i         (row_i),
    .font_size_we_i(font_size_we_i),
    .font_size_i   (font_size_i),
    .char_valid_o  (char_valid_o),
    .column_o      (column_o),
    .row_out_o     (row_out_o),
    .char_code_o   (char_code_o),
    .is_last_o     (is_last_o)
  );

  // font height as the block should hold it
  logic [7:0]  font_height = FONT_SIZE_RST;
  digit_char_t pending_chars[$];
  number_req_t dir_items[$];
  string       dir_text[$];
  int unsigned errors      = 0;
  int unsigned numbers_in  = 0;
  int unsigned chars_seen  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned burst_left  = 0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // expected characters of one number under the current font height
  function automatic void predict_chars(input number_req_t req);
    int unsigned     n;
    int unsigned     t;
    longint unsigned scale;
    longint unsigned val;
    logic [7:0]      step;
    logic [3:0]      d;
    bit              shown;
    digit_char_t     c;
    n     = (req.count > MAX_POS) ? MAX_POS : req.count;
    step  = font_height >> 1;
    val   = req.value;
    scale = 1;
    shown = 1'b0;
    for (t = 1; t < n; t++) scale *= 10;
    for (t = 0; t < n; t++) begin
      d         = 4'((val / scale) % 10);
      c.is_last = (t == n - 1);
      c.column  = 8'(req.start + step * t);
      c.row     = req.row;
      // blank leading zeros, never the last position
      if (!shown && !c.is_last && d == 4'd0) begin
        c.code = CODE_SPACE;
      end else begin
        shown  = 1'b1;
        c.code = CODE_ZERO + 6'(d);
      end
      pending_chars.push_back(c);
      scale /= 10;
    end
  endfunction

  // expected characters typed in as text
  function automatic void queue_typed_text(input number_req_t req, input string txt);
    int unsigned t;
    logic [7:0]  step;
    digit_char_t c;
    step = font_height >> 1;
    for (t = 0; t < txt.len(); t++) begin
      c.column  = 8'(req.start + step * t);
      c.row     = req.row;
      c.code    = 6'(txt[t]);
      c.is_last = (t == txt.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // drive one number and wait for its transfer; empty text means use the predictor
  task automatic send_number(input number_req_t req, input string txt);
    start_i        <= 1'b1;
    value_i        <= req.value;
    digit_count_i  <= req.count;
    start_column_i <= req.start;
    row_i          <= req.row;
    do @(posedge clk_i); while (busy_o);
    numbers_in++;
    if (txt.len() == 0) predict_chars(req);
    else queue_typed_text(req, txt);
    // burst pacing: keep start high inside a burst, gap between bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // let every expected character arrive, then let the pipeline settle
  task automatic wait_all_done();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // font height write while idle
  task automatic write_font_size(input logic [7:0] v);
    font_size_we_i <= 1'b1;
    font_size_i    <= v;
    @(posedge clk_i);
    font_size_we_i <= 1'b0;
    font_height = v;
    @(posedge clk_i);
  endtask

  task automatic add_row(input logic [VAL_W-1:0] v, input logic [COUNT_W-1:0] n,
                         input logic [7:0] col, input logic [7:0] r, input string txt);
    number_req_t req;
    req = '{value: v, count: n, start: col, row: r};
    dir_items.push_back(req);
    dir_text.push_back(txt);
  endtask

  // random number biased toward digit boundaries and small values
  function automatic number_req_t random_number();
    number_req_t     req;
    longint unsigned p10;
    int unsigned     k;
    int unsigned     pick;
    pick = $urandom_range(0, 19);
    if (pick < 16) req.count = COUNT_W'($urandom_range(1, MAX_POS));
    else if (pick < 18) req.count = '0;
    else req.count = COUNT_W'($urandom_range(MAX_POS + 1, 15));
    case ($urandom_range(0, 3))
      0: begin
        req.value = $urandom;
      end
      1: begin
        req.value = $urandom >> $urandom_range(0, 31);
      end
      2: begin
        p10 = 1;
        k   = $urandom_range(0, 9);
        repeat (k) p10 *= 10;
        req.value = VAL_W'(p10 - 1 + $urandom_range(0, 1));
      end
      default: begin
        req.value = $urandom_range(0, 999);
      end
    endcase
    req.start = 8'($urandom_range(0, 255));
    req.row   = 8'($urandom_range(0, 255));
    return req;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    digit_char_t exp_c;
    if (rst_ni && char_valid_o) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character, expected none, got code %0h col %0d",
                 $time, char_code_o, column_o);
      end else begin
        exp_c = pending_chars.pop_front();
        chars_seen++;
        if (column_o !== exp_c.column) begin
          errors++;
          $display("%0t: column mismatch, expected %0d, got %0d", $time, exp_c.column, column_o);
        end
        if (row_out_o !== exp_c.row) begin
          errors++;
          $display("%0t: row mismatch, expected %0d, got %0d", $time, exp_c.row, row_out_o);
        end
        if (char_code_o !== exp_c.code) begin
          errors++;
          $display("%0t: char code mismatch, expected %0h, got %0h",
                   $time, exp_c.code, char_code_o);
        end
        if (is_last_o !== exp_c.is_last) begin
          errors++;
          $display("%0t: last flag mismatch, expected %0b, got %0b",
                   $time, exp_c.is_last, is_last_o);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] phase_sizes[NUM_PHASES];
    int unsigned i;
    int unsigned p;

    // directed table, run at the reset font height (column step 8)
    add_row(32'd0,          4'd1,  8'd0,   8'd0,   "0");
    add_row(32'd0,          4'd10, 8'd0,   8'd255, "         0");
    add_row(32'hFFFF_FFFF,  4'd10, 8'd255, 8'd0,   "4294967295");
    add_row(32'hFFFF_FFFF,  4'd15, 8'd128, 8'd17,  "4294967295");
    add_row(32'hFFFF_FFFF,  4'd1,  8'd3,   8'd4,   "5");
    add_row(32'hFFFF_FFFF,  4'd0,  8'd0,   8'd0,   "");
    add_row(32'd7,          4'd4,  8'd10,  8'd2,   "   7");
    add_row(32'd1000,       4'd3,  8'd20,  8'd3,   "  0");
    add_row(32'd1000000000, 4'd10, 8'd0,   8'd1,   "1000000000");
    add_row(32'd123456,     4'd4,  8'd40,  8'd5,   "3456");
    add_row(32'd5,          4'd11, 8'd0,   8'd6,   "         5");
    add_row(32'd4000000009, 4'd10, 8'd200, 8'd7,   "4000000009");
    add_row(32'd10,         4'd2,  8'd250, 8'd8,   "10");
    add_row(32'd0,          4'd12, 8'd9,   8'd9,   "         0");
    add_row(32'd100,        4'd3,  8'd0,   8'd10,  "100");
    add_row(32'd9,          4'd1,  8'd33,  8'd11,  "9");
    add_row(32'd90,         4'd2,  8'd60,  8'd12,  "90");
    add_row(32'd1,          4'd10, 8'd100, 8'd13,  "         1");
    add_row(32'h5555_AAAA,  4'd8,  8'h55,  8'hAA,  "");
    add_row(32'hAAAA_5555,  4'd6,  8'hAA,  8'h55,  "");
    add_row(32'h0001_0000,  4'd13, 8'd1,   8'd2,   "");
    add_row(32'd99999,      4'd14, 8'd77,  8'd66,  "");

    phase_sizes[0] = 8'hFF;
    phase_sizes[1] = 8'h00;
    phase_sizes[2] = 8'h01;
    phase_sizes[3] = 8'd3;
    phase_sizes[4] = 8'($urandom_range(0, 255));
    phase_sizes[5] = 8'($urandom_range(0, 255));

    // reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (i = 0; i < dir_items.size(); i++) send_number(dir_items[i], dir_text[i]);
    wait_all_done();

    // random phases, one font height each
    for (p = 0; p < NUM_PHASES; p++) begin
      write_font_size(phase_sizes[p]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_number(random_number(), "");
        // occasional full drain in mid-phase
        if ($urandom_range(0, 24) == 0) wait_all_done();
      end
      wait_all_done();
    end

    $display("covered %0d numbers, %0d characters, reset font height plus %0d others",
             numbers_in, chars_seen, NUM_PHASES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ddf_pkg.sv
rtl/ddf_dabble_stage.sv
rtl/decimal_digit_formatter.sv
rtl/ddf_checker.sv
tb/tb_decimal_digit_formatter.sv
